>>> rtl/bounded_le_leb128_serializer_top_macros.svh
// Assertion macros for the serializer top level.
`ifndef BOUNDED_LE_LEB128_SERIALIZER_TOP_MACROS_SVH
`define BOUNDED_LE_LEB128_SERIALIZER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BL128_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BL128_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bl128_pkg.sv
// Shared types and constants of the bounded LE / LEB128 serializer.
`default_nettype none

package bl128_pkg;

	localparam int unsigned CAP_BITS_DEF = 16;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam logic [15:0] CAP_RESET    = 16'hFFFF;

	localparam logic [7:0]  LEB_MASK    = 8'h7f;
	localparam logic [7:0]  LEB_MORE    = 8'h80;
	localparam int unsigned LEB_SHIFT   = 7;
	localparam int unsigned LEB_MAX_LEN = 10;

	// action codes
	localparam logic [2:0] ACT_NEW = 3'd0;
	localparam logic [2:0] ACT_B1  = 3'd1;
	localparam logic [2:0] ACT_B2  = 3'd2;
	localparam logic [2:0] ACT_B3  = 3'd3;
	localparam logic [2:0] ACT_B4  = 3'd4;
	localparam logic [2:0] ACT_B8  = 3'd5;
	localparam logic [2:0] ACT_LEB = 3'd6;

	localparam int unsigned BEAT_CNT_W = 4;

	typedef enum logic [1:0] {
		K_NEW,
		K_FIXED,
		K_LEB,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [15:0] byte_offset;
		logic        last;
		logic        overflowed;
		logic [15:0] bytes_written;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_kind_t             kind;
		logic [BEAT_CNT_W-1:0] cnt;
		logic [63:0]           value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

>>> rtl/bl128_front.sv
// Front end: classifies an input beat into a serializer command.
`default_nettype none

module bl128_front import bl128_pkg::*; (
	input  in_item_t item,
	output cmd_t     cmd
);

	logic [BEAT_CNT_W-1:0] leb_len;

	// LEB128 length: one byte per 7-bit group up to the highest nonzero one, at least one
	always_comb begin
		leb_len = BEAT_CNT_W'(1);
		for (int g = 1; g < int'(LEB_MAX_LEN); g++) begin
			if ((item.value >> (LEB_SHIFT * g)) != 64'd0) begin
				leb_len = BEAT_CNT_W'(g + 1);
			end
		end
	end

	always_comb begin
		cmd.value = item.value;
		cmd.cnt   = BEAT_CNT_W'(1);
		cmd.kind  = K_NOP;
		case (item.action) inside
			ACT_NEW: begin
				cmd.kind = K_NEW;
			end
			ACT_B1, ACT_B2, ACT_B3, ACT_B4: begin
				cmd.kind = K_FIXED;
				cmd.cnt  = BEAT_CNT_W'(item.action);
			end
			ACT_B8: begin
				cmd.kind = K_FIXED;
				cmd.cnt  = BEAT_CNT_W'(8);
			end
			ACT_LEB: begin
				cmd.kind = K_LEB;
				cmd.cnt  = leb_len;
			end
			default: begin
				cmd.kind = K_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/bl128_queue.sv
// Short command queue between front and back.
`default_nettype none

module bl128_queue import bl128_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wdata,
	input  logic    pop,
	output cmd_t    rdata,
	output q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/bl128_back.sv
// Back end: holds position and overflow state, emits one result beat per cycle unless stalled.
`default_nettype none

module bl128_back import bl128_pkg::*; #(
	parameter int unsigned CAPACITY_BITS = CAP_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  q_stat_t     q_stat,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        res_valid,
	input  logic        res_stall,
	output out_item_t   res
);

	localparam int unsigned PW = CAPACITY_BITS;
	localparam int unsigned SW = CAPACITY_BITS + 1;

	logic [15:0]           cap_q;
	logic [PW-1:0]         pos_q;
	logic                  ovf_q;
	logic                  busy_q;
	logic                  first_q;
	cmd_kind_t             kind_q;
	logic [BEAT_CNT_W-1:0] cnt_q;
	logic [63:0]           val_q;
	logic                  res_valid_q;
	out_item_t             res_q;

	logic [PW-1:0]   cap_eff;
	logic            fit_n;
	logic            fit_1;
	logic            adv;
	logic            fin;
	logic            more;
	logic [PW-1:0]   pos_n;
	logic            ovf_n;
	logic [63:0]     val_n;
	out_item_t       o;

	assign cap_eff = PW'(cap_q);
	assign fit_n   = ({1'b0, pos_q} + SW'(cnt_q)) <= {1'b0, cap_eff};
	assign fit_1   = pos_q < cap_eff;
	assign adv     = busy_q && (!res_valid_q || !res_stall);
	assign q_pop   = !q_stat.empty && (!busy_q || (adv && fin));
	assign more    = (cnt_q != BEAT_CNT_W'(1));

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		o           = '0;
		pos_n       = pos_q;
		ovf_n       = ovf_q;
		val_n       = val_q;
		fin         = 1'b1;
		o.byte_offset = 16'(pos_q);
		case (kind_q)
			K_NEW: begin
				pos_n         = '0;
				ovf_n         = 1'b0;
				o.byte_offset = '0;
			end
			K_FIXED: begin
				if (first_q && !fit_n) begin
					ovf_n = 1'b1;
				end else begin
					o.out_byte   = val_q[7:0];
					o.byte_valid = 1'b1;
					pos_n        = pos_q + 1'b1;
					val_n        = val_q >> 8;
					fin          = !more;
				end
			end
			K_LEB: begin
				// a byte that does not fit still takes a beat
				if (fit_1) begin
					o.out_byte   = (val_q[7:0] & LEB_MASK) | (more ? LEB_MORE : 8'h00);
					o.byte_valid = 1'b1;
					pos_n        = pos_q + 1'b1;
				end else begin
					ovf_n = 1'b1;
				end
				val_n = val_q >> LEB_SHIFT;
				fin   = !more;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
		o.last          = fin;
		o.overflowed    = ovf_n;
		o.bytes_written = 16'(pos_n);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= o;
		end
		if (q_pop) begin
			kind_q <= q_cmd.kind;
			cnt_q  <= q_cmd.cnt;
			val_q  <= q_cmd.value;
		end else if (adv) begin
			val_q <= val_n;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			busy_q      <= 1'b0;
			first_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (adv) begin
				pos_q       <= pos_n;
				ovf_q       <= ovf_n;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
			end else if (adv) begin
				first_q <= 1'b0;
				if (fin) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/bounded_le_leb128_serializer_top.sv
// Path: input beat -> command queue -> back-end command registers -> result register.
// Throughput: one result beat per cycle from the back-end sequencer unless res_stall
// holds it; n beats for an n-byte fixed write that fits, 1 to 10 for LEB128, else 1.
// The command queue lets the next input beat in while results are still going out.
// Reset: position and overflow cleared, capacity 65535, queue and output empty.
`default_nettype none

`include "bounded_le_leb128_serializer_top_macros.svh"

module bounded_le_leb128_serializer_top import bl128_pkg::*; #(
	parameter int unsigned CAPACITY_BITS = CAP_BITS_DEF,
	parameter int unsigned Q_DEPTH       = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	output logic        res_valid,
	input  logic        res_stall,
	output out_item_t   res
);

	cmd_t    f_cmd;
	cmd_t    q_cmd;
	q_stat_t q_stat;
	logic    q_pop;

	assign item_stall = q_stat.full;

	bl128_front u_front (
		.item (item),
		.cmd  (f_cmd)
	);

	bl128_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_valid),
		.wdata  (f_cmd),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.stat   (q_stat)
	);

	bl128_back #(
		.CAPACITY_BITS (CAPACITY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	`BL128_ASSERT_NOW(a_pos_advance, res_valid && res.byte_valid, res.bytes_written == res.byte_offset + 16'd1, "stored byte must advance the position by one")
	`BL128_ASSERT_NOW(a_status_zero, res_valid && !res.byte_valid, res.out_byte == 8'd0, "status beat must carry a zero byte")
	`BL128_ASSERT_NOW(a_mid_beat, res_valid && !res.last, res.byte_valid || res.overflowed, "non-final beat is a stored byte or a dropped LEB128 byte")
	`BL128_ASSERT_NEXT(a_queued, item_valid && !item_stall, !q_stat.empty, "accepted input beat must be queued")

endmodule

`default_nettype wire
